@@ rtl/core/sitd_pkg.sv @@
// Shared constants, types and the double-dabble step for the integer to ASCII converter.
package sitd_pkg;

    localparam int VAL_W      = 32;
    localparam int NDIG       = 10;
    localparam int DD_BITS    = 4;                 // magnitude bits consumed per stage
    localparam int DD_STAGES  = VAL_W / DD_BITS;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef logic [NDIG-1:0][3:0] t_bcd;

    typedef struct packed {
        t_bcd             bcd;
        logic [VAL_W-1:0] bin;
    } t_dd;

    // Shift-and-add-3 over DD_BITS magnitude bits.
    function automatic t_dd dd_step(t_dd s);
        t_dd r;
        r = s;
        for (int it = 0; it < DD_BITS; it++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (r.bcd[d] >= 4'd5) begin
                    r.bcd[d] = r.bcd[d] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/signed_int_to_ascii_decimal_unit.sv @@
// Signed 32-bit integer to ASCII decimal text, one character per output transaction.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  input   | in        | i_valid / o_ready  | i_value, i_pad_digits
//  output  | out       | o_valid / i_ready  | o_ascii_char, o_last
//
// Binary to BCD runs through 8 register stages of 4 shift-add-3 steps each,
// behind an input register; the serializer loads its digits from the last stage.
// The character serializer emits one character per cycle while i_ready is high
// and takes a new number only after the last character of the previous one.
// Reset (i_rst_n, synchronous) empties all stages. When the serializer is busy
// with a number held at the pipe end, the whole pipe holds and o_ready is low;
// nothing is dropped or repeated.
module signed_int_to_ascii_decimal_unit
    import sitd_pkg::*;
#(
    parameter int MAX_PAD = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic [4:0]  i_pad_digits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_ascii_char,
    output logic        o_last
);

    localparam int PW = $clog2(MAX_PAD + 1);
    localparam int CW = (PW > 5) ? PW : 5;

    // pipe registers; index 0 is the input register
    logic          r_vld [0:DD_STAGES];
    t_dd           r_dd  [0:DD_STAGES];
    logic          r_neg [0:DD_STAGES];
    logic [PW-1:0] r_pad [0:DD_STAGES];

    // serializer
    logic          r_busy;
    logic          r_sign;
    logic [PW-1:0] r_cnt;
    logic [3:0]    r_len;
    t_bcd          r_dig;

    logic          en;
    logic          adv;
    logic          in_neg;
    logic [31:0]   in_mag;
    logic [CW-1:0] pad_ext;
    logic [PW-1:0] pad_sat;
    logic [3:0]    ld_len;
    logic [PW-1:0] ld_cnt;
    logic [3:0]    cur_dig;
    logic [7:0]    n_char;
    logic          n_last;

    assign en      = !(r_vld[DD_STAGES] && r_busy);
    assign o_ready = en;
    assign adv     = !o_valid || i_ready;

    assign in_neg  = i_value[31];
    assign in_mag  = in_neg ? (32'd0 - i_value) : i_value;
    assign pad_ext = CW'(i_pad_digits);
    assign pad_sat = (pad_ext > CW'(MAX_PAD)) ? PW'(MAX_PAD) : PW'(pad_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DD_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DD_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0].bcd <= '0;
            r_dd[0].bin <= in_mag;
            r_neg[0]    <= in_neg;
            r_pad[0]    <= pad_sat;
            for (int k = 1; k <= DD_STAGES; k++) begin
                r_dd[k]  <= dd_step(r_dd[k-1]);
                r_neg[k] <= r_neg[k-1];
                r_pad[k] <= r_pad[k-1];
            end
        end
    end

    // significant digit count, at least one
    always_comb begin
        ld_len = 4'd1;
        for (int d = 0; d < NDIG; d++) begin
            if (r_dd[DD_STAGES].bcd[d] != 4'd0) begin
                ld_len = 4'(d + 1);
            end
        end
        ld_cnt = (r_pad[DD_STAGES] > PW'(ld_len)) ? (r_pad[DD_STAGES] - PW'(1))
                                                  : PW'(ld_len - 4'd1);
    end

    // r_cnt is the digit position being emitted, counting down to zero
    always_comb begin
        cur_dig = 4'd0;
        if (r_cnt < PW'(r_len)) begin
            cur_dig = r_dig[r_cnt[3:0]];
        end
        if (r_sign) begin
            n_char = CH_MINUS;
            n_last = 1'b0;
        end else begin
            n_char = CH_ZERO + {4'd0, cur_dig};
            n_last = (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (adv) begin
                o_valid <= r_busy;
            end
            if (r_busy) begin
                if (adv && !r_sign && r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end else if (r_vld[DD_STAGES]) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (adv) begin
                o_ascii_char <= n_char;
                o_last       <= n_last;
                if (r_sign) begin
                    r_sign <= 1'b0;
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - PW'(1);
                end
            end
        end else if (r_vld[DD_STAGES]) begin
            r_sign <= r_neg[DD_STAGES];
            r_cnt  <= ld_cnt;
            r_len  <= ld_len;
            r_dig  <= r_dd[DD_STAGES].bcd;
        end
    end

endmodule

@@ tb/signed_int_to_ascii_decimal_unit_tb.sv @@
// Self-checking testbench for the signed integer to ASCII decimal converter.
module signed_int_to_ascii_decimal_unit_tb;
    import sitd_pkg::*;

    localparam int  MAX_PAD        = 20;
    localparam int  CLK_HALF       = 10;
    localparam int  RX_HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES   = 40;
    localparam time RUN_LIMIT      = 40_000_000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_value;
    logic [4:0]  i_pad_digits;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_ascii_char;
    logic        o_last;

    t_text_char  pending_chars[$];
    int          err_count   = 0;
    bit          tx_gaps_on  = 1'b1;
    bit          rx_stalls_on = 1'b1;
    bit          rx_hold_req = 1'b0;

    signed_int_to_ascii_decimal_unit #(
        .MAX_PAD(MAX_PAD)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_value(i_value),
        .i_pad_digits(i_pad_digits),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_ascii_char(o_ascii_char),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 60);
    endfunction

    // Expected text of one number: optional '-', zero pad, then the digits.
    function automatic void predict_decimal_text(logic [31:0] val, logic [4:0] pad_req);
        logic [31:0] mag;
        logic [3:0]  digs[10];
        int          ndig;
        int          pad;
        int          width;
        int          nchar;
        int          k;
        t_text_char  c;
        mag   = val[31] ? (32'd0 - val) : val;
        ndig  = 0;
        do begin
            digs[ndig] = 4'(mag % 10);
            mag        = mag / 10;
            ndig++;
        end while (mag != 0);
        pad   = (int'(pad_req) > MAX_PAD) ? MAX_PAD : int'(pad_req);
        width = (pad > ndig) ? pad : ndig;
        nchar = width + (val[31] ? 1 : 0);
        k     = 0;
        if (val[31]) begin
            c.ch   = CH_MINUS;
            c.last = (k == nchar - 1);
            pending_chars.push_back(c);
            k++;
        end
        for (int i = 0; i < width; i++) begin
            if (i < width - ndig) begin
                c.ch = CH_ZERO;
            end else begin
                c.ch = CH_ZERO + 8'(digs[width - 1 - i]);
            end
            c.last = (k == nchar - 1);
            pending_chars.push_back(c);
            k++;
        end
    endfunction

    task automatic send_number(logic [31:0] val, logic [4:0] pad_req);
        int gap;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_value      <= val;
        i_pad_digits <= pad_req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_decimal_text(val, pad_req);
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_value      <= $urandom();
            i_pad_digits <= 5'($urandom());
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, plus one long hold when a test asks for it.
    initial begin : rx_stall_proc
        int gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                i_ready <= 1'b1;
            end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                gap = 1 + pick_gap();
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_chars
        t_text_char exp_c;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                $error("ascii_char: unexpected transaction, got %h last %b",
                       o_ascii_char, o_last);
                err_count++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_ascii_char !== exp_c.ch) begin
                    $error("ascii_char: expected %h, got %h", exp_c.ch, o_ascii_char);
                    err_count++;
                end
                if (o_last !== exp_c.last) begin
                    $error("last: expected %b, got %b", exp_c.last, o_last);
                    err_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_number(32'd0, 5'd0);
        send_number(32'd0, 5'd20);
        send_number(32'd0, 5'd31);
        send_number(32'd1, 5'd0);
        send_number(-32'sd1, 5'd0);
        send_number(32'h7fff_ffff, 5'd0);
        send_number(32'h8000_0000, 5'd0);
        send_number(32'h8000_0000, 5'd31);
        send_number(32'h8000_0001, 5'd12);
        send_number(32'd9, 5'd1);
        send_number(32'd10, 5'd0);
        send_number(-32'sd10, 5'd3);
        send_number(32'd123, 5'd2);
        send_number(32'd123, 5'd3);
        send_number(32'd123, 5'd4);
        send_number(-32'sd5, 5'd21);
        send_number(32'd42, 5'd20);
        send_number(32'd1_000_000_000, 5'd16);
        send_number(32'd999_999_999, 5'd10);
        send_number(-32'sd99_999, 5'd15);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        logic [31:0] val;
        logic [31:0] p10;
        logic [4:0]  pad;
        int          r;
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: val = $urandom();
                3, 4: begin
                    val = $urandom_range(0, 999);
                    if ($urandom_range(0, 1) == 1) val = -val;
                end
                5, 6: begin
                    p10 = 32'd1;
                    repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                    val = p10 + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1) == 1) val = -val;
                end
                7: val = ($urandom_range(0, 1) == 1 ? 32'h8000_0000 : 32'h7fff_ffff)
                         + $urandom_range(0, 3) - 1;
                default: begin
                    val = $urandom_range(0, 99_999);
                    if ($urandom_range(0, 1) == 1) val = -val;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < 45) begin
                pad = 5'd0;
            end else if (r < 85) begin
                pad = 5'($urandom_range(1, 12));
            end else begin
                pad = 5'($urandom_range(13, 31));
            end
            send_number(val, pad);
        end
        stop_sending();
        wait_drained();
    endtask

    // No idling on either side.
    task automatic test_back_to_back();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random(15);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Receiver holds off long enough that the pipe fills and the input stalls.
    task automatic test_output_backpressure();
        tx_gaps_on  = 1'b0;
        rx_hold_req = 1'b1;
        test_random(25);
        tx_gaps_on  = 1'b1;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = 32'd0;
        i_pad_digits = 5'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(90);
        test_back_to_back();
        test_output_backpressure();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
